FILE: design/sws_pkg.sv
package sws_pkg;

    localparam int WINDOW_SIZE_DEF = 10;

    localparam int SAMPLE_W = 16;
    localparam int TIME_W   = 32;
    localparam int TARGET_W = 14;
    localparam int TOL_W    = 5;
    localparam int DEV_W    = 6;
    localparam int COUNT_W  = 4;
    localparam int CFG_W    = 14;
    localparam int CFG_IDX_W = 2;

    localparam logic [TIME_W-1:0] GAP_LIMIT_MS  = 32'd4500;
    localparam logic [TIME_W-1:0] SPAN_LIMIT_MS = 32'd22000;
    localparam logic [6:0]        PERCENT_SCALE = 7'd100;

    localparam logic [TARGET_W-1:0] TARGET_RST = 14'd0;
    localparam logic [TOL_W-1:0]    TOL_RST    = 5'd5;
    localparam logic [DEV_W-1:0]    DEV_RST    = 6'd20;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOL    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEV    = 2'd2;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPLY,
        ST_CHECK,
        ST_SCAN,
        ST_DIV,
        ST_PROD,
        ST_DEV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic apply;
        logic check;
        logic scan;
        logic divide;
        logic product;
        logic deviate;
        logic result_load;
    } t_ctrl_cmd;

    typedef struct packed {
        logic is_clear;
        logic ready_now;
        logic scan_last;
        logic out_free;
    } t_ctrl_status;

endpackage

FILE: design/sws_ctrl.sv
module sws_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  sws_pkg::t_ctrl_status i_status,
    output sws_pkg::t_ctrl_cmd    o_cmd
);

    sws_pkg::t_state r_state;
    sws_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sws_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            sws_pkg::ST_IDLE: begin
                if (i_rst_n) begin
                    o_in_stall = 1'b0;
                    if (i_in_valid) begin
                        o_cmd.capture = 1'b1;
                        n_state       = sws_pkg::ST_APPLY;
                    end
                end
            end
            sws_pkg::ST_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = i_status.is_clear ? sws_pkg::ST_DONE : sws_pkg::ST_CHECK;
            end
            sws_pkg::ST_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_status.ready_now ? sws_pkg::ST_SCAN : sws_pkg::ST_DONE;
            end
            sws_pkg::ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_last) begin
                    n_state = sws_pkg::ST_DIV;
                end
            end
            sws_pkg::ST_DIV: begin
                o_cmd.divide = 1'b1;
                n_state      = sws_pkg::ST_PROD;
            end
            sws_pkg::ST_PROD: begin
                o_cmd.product = 1'b1;
                n_state       = sws_pkg::ST_DEV;
            end
            sws_pkg::ST_DEV: begin
                o_cmd.deviate = 1'b1;
                n_state       = sws_pkg::ST_DONE;
            end
            sws_pkg::ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.result_load = 1'b1;
                    n_state           = sws_pkg::ST_IDLE;
                end
            end
        endcase
    end

endmodule

FILE: design/sws_dp.sv
module sws_dp #(
    parameter int WINDOW_SIZE = sws_pkg::WINDOW_SIZE_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sws_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [sws_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                i_command,
    input  logic [sws_pkg::SAMPLE_W-1:0]        i_sample_value,
    input  logic [sws_pkg::TIME_W-1:0]          i_sample_time_ms,
    input  sws_pkg::t_ctrl_cmd                  i_cmd,
    output sws_pkg::t_ctrl_status               o_status,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_window_ready,
    output logic                                o_stable,
    output logic [sws_pkg::SAMPLE_W-1:0]        o_average,
    output logic                                o_within_deviation,
    output logic [sws_pkg::COUNT_W-1:0]         o_held_count,
    output logic                                o_gap_cleared
);

    localparam int IDX_W  = $clog2(WINDOW_SIZE);
    localparam int CNT_W  = $clog2(WINDOW_SIZE + 1);
    localparam int SUM_W  = sws_pkg::SAMPLE_W + $clog2(WINDOW_SIZE);
    localparam int SHIFT  = SUM_W + $clog2(WINDOW_SIZE);
    localparam int RCP_W  = SUM_W + 1;
    localparam int PROD_W = SUM_W + RCP_W;
    localparam int MUL_W  = sws_pkg::SAMPLE_W + 7;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(WINDOW_SIZE) - 64'd1) / 64'(WINDOW_SIZE);
    localparam logic [RCP_W-1:0] RECIP   = RECIP_FULL[RCP_W-1:0];
    localparam logic [SUM_W-1:0] HALF_N  = SUM_W'(WINDOW_SIZE / 2);
    localparam logic [IDX_W-1:0] LAST_IX = IDX_W'(WINDOW_SIZE - 1);
    localparam logic [CNT_W-1:0] FULL_CT = CNT_W'(WINDOW_SIZE);

    logic [sws_pkg::TARGET_W-1:0] r_target;
    logic [sws_pkg::TOL_W-1:0]    r_tol;
    logic [sws_pkg::DEV_W-1:0]    r_dev;

    logic [sws_pkg::SAMPLE_W-1:0] r_samp [WINDOW_SIZE];
    logic [sws_pkg::TIME_W-1:0]   r_time [WINDOW_SIZE];
    logic [CNT_W-1:0]             r_count;
    logic [IDX_W-1:0]             r_slot;
    logic [sws_pkg::TIME_W-1:0]   r_newest;

    logic                         r_in_cmd;
    logic [sws_pkg::SAMPLE_W-1:0] r_in_value;
    logic [sws_pkg::TIME_W-1:0]   r_in_time;

    logic                         r_gap;
    logic                         r_ready;
    logic [IDX_W-1:0]             r_idx;
    logic [SUM_W-1:0]             r_sum;
    logic [sws_pkg::SAMPLE_W-1:0] r_lo;
    logic [sws_pkg::SAMPLE_W-1:0] r_hi;
    logic [sws_pkg::SAMPLE_W-1:0] r_spread;
    logic [PROD_W-1:0]            r_prod;
    logic [sws_pkg::SAMPLE_W-1:0] r_avg;
    logic [MUL_W-1:0]             r_spread_lhs;
    logic [MUL_W-1:0]             r_spread_rhs;
    logic [MUL_W-1:0]             r_dev_lhs;
    logic [MUL_W-1:0]             r_dev_rhs;

    logic                         r_out_valid;
    logic                         r_o_ready;
    logic                         r_o_stable;
    logic [sws_pkg::SAMPLE_W-1:0] r_o_avg;
    logic                         r_o_within;
    logic [sws_pkg::COUNT_W-1:0]  r_o_count;
    logic                         r_o_gap;

    logic                         w_gap;
    logic [IDX_W-1:0]             w_base;
    logic [IDX_W-1:0]             w_slot_next;
    logic [CNT_W-1:0]             w_count_next;
    logic                         w_ready_now;
    logic [sws_pkg::SAMPLE_W-1:0] w_scan_val;
    logic [sws_pkg::SAMPLE_W-1:0] w_target_ext;
    logic [sws_pkg::SAMPLE_W-1:0] w_diff;
    logic [CNT_W+sws_pkg::COUNT_W-1:0] w_count_ext;
    logic                         w_out_free;

    assign w_gap = (r_in_cmd == sws_pkg::CMD_ADD) && (r_count != '0)
                   && ((r_in_time - r_newest) > sws_pkg::GAP_LIMIT_MS);
    assign w_base       = w_gap ? '0 : r_slot;
    assign w_slot_next  = (w_base == LAST_IX) ? '0 : w_base + 1'b1;
    assign w_count_next = w_gap ? CNT_W'(1)
                        : ((r_count < FULL_CT) ? r_count + 1'b1 : r_count);
    assign w_ready_now  = (r_count == FULL_CT)
                        && ((r_newest - r_time[r_slot]) <= sws_pkg::SPAN_LIMIT_MS);
    assign w_scan_val   = r_samp[r_idx];
    assign w_target_ext = {2'b00, r_target};
    assign w_diff       = (r_avg > w_target_ext) ? r_avg - w_target_ext : w_target_ext - r_avg;
    assign w_count_ext  = {{sws_pkg::COUNT_W{1'b0}}, r_count};
    assign w_out_free   = !r_out_valid || !i_out_stall;

    assign o_status.is_clear  = (r_in_cmd == sws_pkg::CMD_CLEAR);
    assign o_status.ready_now = w_ready_now;
    assign o_status.scan_last = (r_idx == LAST_IX);
    assign o_status.out_free  = w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= sws_pkg::TARGET_RST;
            r_tol    <= sws_pkg::TOL_RST;
            r_dev    <= sws_pkg::DEV_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sws_pkg::REG_TARGET: r_target <= i_cfg_data[sws_pkg::TARGET_W-1:0];
                sws_pkg::REG_TOL:    r_tol    <= i_cfg_data[sws_pkg::TOL_W-1:0];
                sws_pkg::REG_DEV:    r_dev    <= i_cfg_data[sws_pkg::DEV_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply && (r_in_cmd == sws_pkg::CMD_ADD)) begin
            r_samp[w_base] <= r_in_value;
            r_time[w_base] <= r_in_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_slot      <= '0;
            r_newest    <= '0;
            r_gap       <= 1'b0;
            r_ready     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.apply) begin
                r_ready <= 1'b0;
                if (r_in_cmd == sws_pkg::CMD_CLEAR) begin
                    r_count <= '0;
                    r_slot  <= '0;
                    r_gap   <= 1'b0;
                end else begin
                    r_count  <= w_count_next;
                    r_slot   <= w_slot_next;
                    r_newest <= r_in_time;
                    r_gap    <= w_gap;
                end
            end
            if (i_cmd.check) begin
                r_ready <= w_ready_now;
            end
            if (i_cmd.result_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in_cmd   <= i_command;
            r_in_value <= i_sample_value;
            r_in_time  <= i_sample_time_ms;
        end
        if (i_cmd.check) begin
            r_idx <= '0;
            r_sum <= '0;
            r_lo  <= '1;
            r_hi  <= '0;
        end
        if (i_cmd.scan) begin
            r_idx <= r_idx + 1'b1;
            r_sum <= r_sum + SUM_W'(w_scan_val);
            if (w_scan_val < r_lo) r_lo <= w_scan_val;
            if (w_scan_val > r_hi) r_hi <= w_scan_val;
        end
        if (i_cmd.divide) begin
            r_prod   <= PROD_W'(r_sum + HALF_N) * PROD_W'(RECIP);
            r_spread <= r_hi - r_lo;
        end
        if (i_cmd.product) begin
            r_avg        <= r_prod[SHIFT +: sws_pkg::SAMPLE_W];
            r_spread_lhs <= MUL_W'(r_spread) * MUL_W'(sws_pkg::PERCENT_SCALE);
            r_spread_rhs <= MUL_W'(r_target) * MUL_W'(r_tol);
        end
        if (i_cmd.deviate) begin
            r_dev_lhs <= MUL_W'(w_diff) * MUL_W'(sws_pkg::PERCENT_SCALE);
            r_dev_rhs <= MUL_W'(r_target) * MUL_W'(r_dev);
        end
        if (i_cmd.result_load) begin
            r_o_ready  <= r_ready;
            r_o_stable <= r_ready && (r_target != '0) && (r_spread_lhs <= r_spread_rhs);
            r_o_avg    <= r_ready ? r_avg : '0;
            r_o_within <= r_ready && (r_dev_lhs <= r_dev_rhs);
            r_o_count  <= w_count_ext[sws_pkg::COUNT_W-1:0];
            r_o_gap    <= r_gap;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_window_ready     = r_o_ready;
    assign o_stable           = r_o_stable;
    assign o_average          = r_o_avg;
    assign o_within_deviation = r_o_within;
    assign o_held_count       = r_o_count;
    assign o_gap_cleared      = r_o_gap;

endmodule

FILE: design/sample_window_stability.sv
// Add that leaves a full window: states apply, check, scan (one stored sample per step),
// divide, product and deviate, then done loads the result once the output is free.
// Add that leaves the window not ready: apply, check, done; clear: apply, done.
// A new item is taken in the cycle after the result is loaded, not before.
// Reset (synchronous, active low) empties the window and restores register defaults.
module sample_window_stability #(
    parameter int WINDOW_SIZE = sws_pkg::WINDOW_SIZE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sws_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sws_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_command,
    input  logic [sws_pkg::SAMPLE_W-1:0]  i_sample_value,
    input  logic [sws_pkg::TIME_W-1:0]    i_sample_time_ms,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_window_ready,
    output logic                          o_stable,
    output logic [sws_pkg::SAMPLE_W-1:0]  o_average,
    output logic                          o_within_deviation,
    output logic [sws_pkg::COUNT_W-1:0]   o_held_count,
    output logic                          o_gap_cleared
);

    sws_pkg::t_ctrl_cmd    w_cmd;
    sws_pkg::t_ctrl_status w_status;

    sws_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    sws_dp #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_command          (i_command),
        .i_sample_value     (i_sample_value),
        .i_sample_time_ms   (i_sample_time_ms),
        .i_cmd              (w_cmd),
        .o_status           (w_status),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_window_ready     (o_window_ready),
        .o_stable           (o_stable),
        .o_average          (o_average),
        .o_within_deviation (o_within_deviation),
        .o_held_count       (o_held_count),
        .o_gap_cleared      (o_gap_cleared)
    );

endmodule

FILE: test/sample_window_stability_test.sv
module sample_window_stability_test;

    localparam int WIN           = sws_pkg::WINDOW_SIZE_DEF;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = WIN + 12;
    localparam int LONG_HOLD     = 400;
    localparam int PHASES        = 7;
    localparam int PHASE_ITEMS   = 240;

    localparam logic [sws_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    typedef struct packed {
        logic                         ready;
        logic                         stable;
        logic [sws_pkg::SAMPLE_W-1:0] average;
        logic                         on_target;
        logic [sws_pkg::COUNT_W-1:0]  count;
        logic                         gap;
    } t_window_result;

    logic                          i_clk            = 1'b0;
    logic                          i_rst_n          = 1'b0;
    logic                          i_cfg_we         = 1'b0;
    logic [sws_pkg::CFG_IDX_W-1:0] i_cfg_index      = '0;
    logic [sws_pkg::CFG_W-1:0]     i_cfg_data       = '0;
    logic                          i_in_valid       = 1'b0;
    logic                          o_in_stall;
    logic                          i_command        = sws_pkg::CMD_ADD;
    logic [sws_pkg::SAMPLE_W-1:0]  i_sample_value   = '0;
    logic [sws_pkg::TIME_W-1:0]    i_sample_time_ms = '0;
    logic                          o_out_valid;
    logic                          i_out_stall      = 1'b0;
    logic                          o_window_ready;
    logic                          o_stable;
    logic [sws_pkg::SAMPLE_W-1:0]  o_average;
    logic                          o_within_deviation;
    logic [sws_pkg::COUNT_W-1:0]   o_held_count;
    logic                          o_gap_cleared;

    t_window_result pending_results[$];
    t_window_result oldest_result;
    int             fail_count   = 0;
    int             cycle_count  = 0;
    bit             hold_request = 1'b0;

    logic [sws_pkg::SAMPLE_W-1:0] win_samples[WIN];
    logic [sws_pkg::TIME_W-1:0]   win_times[WIN];
    int unsigned                  win_held;
    int unsigned                  win_slot;
    logic [sws_pkg::TIME_W-1:0]   win_newest;
    logic [sws_pkg::TARGET_W-1:0] cfg_target;
    logic [sws_pkg::TOL_W-1:0]    cfg_tol;
    logic [sws_pkg::DEV_W-1:0]    cfg_dev;

    logic [sws_pkg::TIME_W-1:0] stream_time;
    int                         stream_center;
    int                         stream_spread;

    sample_window_stability u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_command          (i_command),
        .i_sample_value     (i_sample_value),
        .i_sample_time_ms   (i_sample_time_ms),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_window_ready     (o_window_ready),
        .o_stable           (o_stable),
        .o_average          (o_average),
        .o_within_deviation (o_within_deviation),
        .o_held_count       (o_held_count),
        .o_gap_cleared      (o_gap_cleared)
    );

    always #1 i_clk = ~i_clk;

    function automatic void empty_window();
        for (int k = 0; k < WIN; k++) begin
            win_samples[k] = '0;
            win_times[k]   = '0;
        end
        win_held = 0;
        win_slot = 0;
    endfunction

    function automatic t_window_result predict_window(logic cmd,
                                                      logic [sws_pkg::SAMPLE_W-1:0] value,
                                                      logic [sws_pkg::TIME_W-1:0] now);
        t_window_result res;
        logic [31:0]    sum;
        logic [31:0]    lo;
        logic [31:0]    hi;
        logic [31:0]    avg;
        logic [31:0]    diff;
        logic [31:0]    tgt;
        logic [31:0]    elapsed;
        logic [31:0]    span;
        res = '0;
        if (cmd == sws_pkg::CMD_CLEAR) begin
            empty_window();
        end else begin
            elapsed = now - win_newest;
            if (win_held > 0 && elapsed > sws_pkg::GAP_LIMIT_MS) begin
                empty_window();
                res.gap = 1'b1;
            end
            win_newest            = now;
            win_samples[win_slot] = value;
            win_times[win_slot]   = now;
            win_slot              = (win_slot + 1) % WIN;
            if (win_held < WIN) win_held++;
            span = win_newest - win_times[win_slot];
            if (win_held == WIN && span <= sws_pkg::SPAN_LIMIT_MS) begin
                sum = 0;
                lo  = 32'(win_samples[0]);
                hi  = 32'(win_samples[0]);
                for (int k = 0; k < WIN; k++) begin
                    sum += 32'(win_samples[k]);
                    if (32'(win_samples[k]) < lo) lo = 32'(win_samples[k]);
                    if (32'(win_samples[k]) > hi) hi = 32'(win_samples[k]);
                end
                avg           = (sum + WIN / 2) / WIN;
                tgt           = 32'(cfg_target);
                diff          = (avg > tgt) ? avg - tgt : tgt - avg;
                res.ready     = 1'b1;
                res.average   = avg[sws_pkg::SAMPLE_W-1:0];
                res.stable    = (tgt != 0) && ((hi - lo) * 32'(sws_pkg::PERCENT_SCALE)
                                               <= tgt * 32'(cfg_tol));
                res.on_target = (diff * 32'(sws_pkg::PERCENT_SCALE) <= tgt * 32'(cfg_dev));
            end
        end
        res.count = win_held[sws_pkg::COUNT_W-1:0];
        return res;
    endfunction

    function automatic void pick_center();
        if (cfg_target != 0 && $urandom_range(0, 3) != 0) stream_center = int'(cfg_target);
        else if ($urandom_range(0, 2) == 0) stream_center = 0;
        else stream_center = int'($urandom_range(0, 65535));
        stream_spread = (int'($urandom_range(0, 25)) * stream_center) / 100;
        if ($urandom_range(0, 1) == 1) stream_spread += int'($urandom_range(1, 4));
    endfunction

    function automatic void check_field(string name, logic [sws_pkg::SAMPLE_W-1:0] want,
                                        logic [sws_pkg::SAMPLE_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    task automatic set_register(logic [sws_pkg::CFG_IDX_W-1:0] index,
                                logic [sws_pkg::CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (index)
            sws_pkg::REG_TARGET: cfg_target = data[sws_pkg::TARGET_W-1:0];
            sws_pkg::REG_TOL:    cfg_tol    = data[sws_pkg::TOL_W-1:0];
            sws_pkg::REG_DEV:    cfg_dev    = data[sws_pkg::DEV_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic send_item(logic cmd, logic [sws_pkg::SAMPLE_W-1:0] value,
                             logic [sws_pkg::TIME_W-1:0] stamp);
        i_in_valid       <= 1'b1;
        i_command        <= cmd;
        i_sample_value   <= value;
        i_sample_time_ms <= stamp;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_results.push_back(predict_window(cmd, value, stamp));
    endtask

    task automatic pause_sender(int cycles);
        if (cycles > 0) begin
            i_in_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic settle_block();
        pause_sender(1);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_random_stream(int items);
        int   burst;
        int   roll;
        int   value;
        logic cmd;
        burst = $urandom_range(1, 16);
        for (int n = 0; n < items; n++) begin
            roll = $urandom_range(0, 99);
            cmd  = sws_pkg::CMD_ADD;
            if (roll < 2) begin
                cmd = sws_pkg::CMD_CLEAR;
                pick_center();
            end else if (roll < 4) begin
                stream_time = $urandom;
                pick_center();
            end else if (roll < 6) begin
                stream_time += $urandom_range(4501, 30000);
                pick_center();
            end else if (roll < 7) begin
                stream_time -= $urandom_range(1, 3000);
            end else if (roll < 9) begin
                stream_time += $urandom_range(2500, 4500);
            end else begin
                stream_time += $urandom_range(0, 2450);
            end
            if ($urandom_range(0, 19) == 0) begin
                value = int'($urandom_range(0, 65535));
            end else begin
                value = stream_center - stream_spread + int'($urandom_range(0, 2 * stream_spread));
                if (value < 0) value = 0;
                if (value > 65535) value = 65535;
            end
            if (cmd == sws_pkg::CMD_CLEAR) send_item(cmd, sws_pkg::SAMPLE_W'($urandom), $urandom);
            else send_item(cmd, value[sws_pkg::SAMPLE_W-1:0], stream_time);
            burst--;
            if (burst == 0) begin
                pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
                burst = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                    : $urandom_range(1, 12);
            end
        end
    endtask

    task automatic test_clear_on_empty();
        send_item(sws_pkg::CMD_CLEAR, '1, '1);
    endtask

    task automatic test_span_limits();
        logic [sws_pkg::TIME_W-1:0] stamp = 32'hFFFF_F000;
        logic [sws_pkg::TIME_W-1:0] step  = sws_pkg::SPAN_LIMIT_MS / (WIN - 1);
        for (int n = 0; n < WIN; n++) begin
            if (n == WIN - 1) stamp += sws_pkg::SPAN_LIMIT_MS - step * (WIN - 2);
            else if (n > 0) stamp += step;
            send_item(sws_pkg::CMD_ADD, (n % 2 == 0) ? 16'hFFFF : 16'h0000, stamp);
        end
        stamp += sws_pkg::GAP_LIMIT_MS;
        send_item(sws_pkg::CMD_ADD, 16'hAAAA, stamp);
        stamp += sws_pkg::GAP_LIMIT_MS + 1;
        send_item(sws_pkg::CMD_ADD, 16'h5555, stamp);
        stream_time = stamp;
    endtask

    task automatic test_zero_target();
        send_item(sws_pkg::CMD_CLEAR, '0, '0);
        for (int n = 0; n < WIN; n++) send_item(sws_pkg::CMD_ADD, '0, stream_time);
    endtask

    task automatic test_register_extremes();
        logic [sws_pkg::CFG_W-1:0] targets[PHASES - 2] =
            '{14'd10000, 14'd16383, 14'd0, 14'd500, 14'd1};
        logic [sws_pkg::CFG_W-1:0] tols[PHASES - 2] =
            '{14'd20, 14'd1, 14'h3FFF, 14'd5, 14'h3FE1};
        logic [sws_pkg::CFG_W-1:0] devs[PHASES - 2] =
            '{14'd50, 14'd1, 14'd63, 14'd20, 14'h3FF2};
        for (int p = 0; p < PHASES; p++) begin
            settle_block();
            if (p < PHASES - 2) begin
                set_register(sws_pkg::REG_TARGET, targets[p]);
                set_register(sws_pkg::REG_TOL, tols[p]);
                set_register(sws_pkg::REG_DEV, devs[p]);
            end else begin
                set_register(sws_pkg::REG_TARGET, sws_pkg::CFG_W'($urandom_range(0, 10000)));
                set_register(sws_pkg::REG_TOL, sws_pkg::CFG_W'($urandom_range(1, 20)));
                set_register(sws_pkg::REG_DEV, sws_pkg::CFG_W'($urandom_range(1, 50)));
            end
            set_register(REG_UNUSED, sws_pkg::CFG_W'($urandom));
            pick_center();
            send_random_stream(PHASE_ITEMS);
        end
    endtask

    task automatic test_output_backpressure();
        settle_block();
        hold_request = 1'b1;
        send_random_stream(100);
    endtask

    initial begin : receiver_pattern
        t_stall_mode mode;
        int          span;
        int          period;
        forever begin
            mode   = t_stall_mode'($urandom_range(0, 3));
            span   = $urandom_range(10, 150);
            period = $urandom_range(2, 7);
            for (int tick = 0; tick < span; tick++) begin
                @(posedge i_clk);
                if (hold_request) begin
                    i_out_stall <= 1'b1;
                    repeat (LONG_HOLD) @(posedge i_clk);
                    hold_request = 1'b0;
                end
                case (mode)
                    STALL_NONE:     i_out_stall <= 1'b0;
                    STALL_LIGHT:    i_out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY:    i_out_stall <= ($urandom_range(0, 3) != 0);
                    STALL_PERIODIC: i_out_stall <= (tick % period == 0);
                    default:        i_out_stall <= 1'b0;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing pending");
                fail_count++;
            end else begin
                oldest_result = pending_results.pop_front();
                check_field("window_ready", oldest_result.ready, o_window_ready);
                check_field("stable", oldest_result.stable, o_stable);
                check_field("average", oldest_result.average, o_average);
                check_field("within_deviation", oldest_result.on_target, o_within_deviation);
                check_field("held_count", oldest_result.count, o_held_count);
                check_field("gap_cleared", oldest_result.gap, o_gap_cleared);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        cfg_target = sws_pkg::TARGET_RST;
        cfg_tol    = sws_pkg::TOL_RST;
        cfg_dev    = sws_pkg::DEV_RST;
        win_newest = '0;
        empty_window();
        stream_time = $urandom;
        pick_center();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_clear_on_empty();
        test_span_limits();
        test_zero_target();
        test_register_extremes();
        test_output_backpressure();
        settle_block();
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/sws_pkg.sv
design/sws_ctrl.sv
design/sws_dp.sv
design/sample_window_stability.sv
test/sample_window_stability_test.sv
